FILE: sv/interval_action_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Uses the clk and arst_n names of the including module.
`ifndef INTERVAL_ACTION_SCHEDULER_DEFINES_SVH
`define INTERVAL_ACTION_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define IAS_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed (same cycle)");

// next-cycle implication
`define IAS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed (next cycle)");

`endif

FILE: sv/ias_pkg.sv
// Types, codes and helper functions for the interval action scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ias_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_STATUS,
		ST_CHECK,
		ST_STOP,
		ST_SCAN,
		ST_RELEASE
	} state_t;

	// input word kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// action types
	localparam logic [1:0] ACT_STROKE     = 2'd0;
	localparam logic [1:0] ACT_KEY_DOWN   = 2'd1;
	localparam logic [1:0] ACT_CLICK      = 2'd2;
	localparam logic [1:0] ACT_MOUSE_DOWN = 2'd3;

	// event codes
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_STROKE     = 3'd1;
	localparam logic [2:0] EV_KEY_DOWN   = 3'd2;
	localparam logic [2:0] EV_KEY_UP     = 3'd3;
	localparam logic [2:0] EV_CLICK      = 3'd4;
	localparam logic [2:0] EV_MOUSE_DOWN = 3'd5;
	localparam logic [2:0] EV_MOUSE_UP   = 3'd6;

	// configuration register indexes
	localparam logic CFG_RUN_ONCE     = 1'b0;
	localparam logic CFG_ACTION_COUNT = 1'b1;
	localparam int   CFG_DW           = 5;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  key;
		logic [2:0]  button;
		logic [15:0] mods;
		logic [23:0] interval;
		logic [23:0] post_delay;
	} entry_t;

	typedef struct packed {
		logic [2:0]  res;
		logic [7:0]  key;
		logic [2:0]  button;
		logic [15:0] mods;
		logic        running;
		logic        last;
	} result_t;

	typedef struct packed {
		logic ent_we;
		logic lf_we;
		logic nz_clr_one;
		logic nz_clr_used;
		logic rd_en;
	} tbl_ctrl_t;

	typedef struct packed {
		logic        borrow;
		logic        below;
		logic [31:0] sum;
	} unit_res_t;

	function automatic logic [2:0] fire_code(input logic [1:0] act);
		logic [2:0] code;
		case (act)
			ACT_STROKE:   code = EV_STROKE;
			ACT_KEY_DOWN: code = EV_KEY_DOWN;
			ACT_CLICK:    code = EV_CLICK;
			default:      code = EV_MOUSE_DOWN;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: sv/interval_action_scheduler.sv
// Interval action scheduler: input word sequencer, output register, config regs.
// Depends on ias_pkg, ias_table, ias_unit and interval_action_scheduler_defines.svh.
//
// Usage:
//  Input channel (in_valid / in_stall) takes one word at a time: a table write,
//  a tick carrying now_ms, or a stop. in_stall stays high from acceptance until
//  the last result word of that input is in the output register.
//  Output channel (out_valid / out_stall) carries result words; last marks the
//  final word of each input. A tick gives one word, a stop one word per held
//  entry (at least one).
//  The table is scanned one entry per cycle through the shared time unit and the
//  registered read port of the entry memory; that scan sets the rate.
//  When the receiver stalls, the scan holds on the pending word; a new input is
//  taken while a finished result still sits in the output register.
//  Reset clears config registers, block-until and all fired stamps; table
//  contents are undefined until written. Config is to be written via cfg_we
//  only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "interval_action_scheduler_defines.svh"

module interval_action_scheduler import ias_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [3:0]        entry_index,
	input  wire logic [1:0]        action_type,
	input  wire logic [7:0]        key_code,
	input  wire logic [2:0]        mouse_button,
	input  wire logic [15:0]       modifiers,
	input  wire logic [23:0]       interval_ms,
	input  wire logic [23:0]       post_delay_ms,
	input  wire logic [31:0]       now_ms,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             event_res,
	output logic [7:0]             event_key,
	output logic [2:0]             event_button,
	output logic [15:0]            event_mods,
	output logic                   running,
	output logic                   last
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t        state_q, state_d;
	logic          run_once_q;
	logic [4:0]    action_count_q;
	logic [31:0]   block_until_q;
	logic [1:0]    item_kind_q;
	logic [3:0]    item_idx_q;
	entry_t        item_entry_q;
	logic [31:0]   item_now_q;
	logic [CW-1:0] cnt;
	logic [CW-1:0] rd_ptr_q;
	logic [IW-1:0] ev_ptr_s1;
	logic          ev_vld_s1;
	logic          pend_vld_q;
	result_t       pend_q;
	logic          out_valid_q;
	result_t       out_q;

	logic          in_accept, out_free, issue_ok, idx_ok, status_run;
	logic          advance, out_load, fire_go, pend_load, stop_go;
	logic          mouse, is_rel;
	result_t       out_d, fire_res, rel_res;
	tbl_ctrl_t     ctrl;
	entry_t        rd_entry;
	logic [31:0]   rd_lf, unit_b;
	logic          nz_sel, all_fired;
	unit_res_t     ures;

	always_comb begin
		if (32'(action_count_q) > MAX_ENTRIES) begin
			cnt = CW'(MAX_ENTRIES);
		end else begin
			cnt = CW'(action_count_q);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign issue_ok   = rd_ptr_q < cnt;
	assign idx_ok     = 32'(item_idx_q) < MAX_ENTRIES;
	assign status_run = !(run_once_q && all_fired);
	assign unit_b     = (state_q == ST_CHECK) ? block_until_q : rd_lf;

	ias_table #(.MAX_ENTRIES(MAX_ENTRIES)) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wr_addr   (IW'(item_idx_q)),
		.wr_entry  (item_entry_q),
		.rd_addr   (rd_ptr_q[IW-1:0]),
		.sel_addr  (ev_ptr_s1),
		.lf_data   (item_now_q),
		.cnt       (cnt),
		.rd_entry  (rd_entry),
		.rd_lf     (rd_lf),
		.nz_sel    (nz_sel),
		.all_fired (all_fired)
	);

	ias_unit u_unit (
		.a   (item_now_q),
		.b   (unit_b),
		.lim (rd_entry.interval),
		.add (rd_entry.post_delay),
		.res (ures)
	);

	// event words built from the entry under evaluation
	always_comb begin
		mouse           = rd_entry.act[1];
		is_rel          = rd_entry.act inside {ACT_KEY_DOWN, ACT_MOUSE_DOWN};
		fire_res.res    = fire_code(rd_entry.act);
		fire_res.key    = mouse ? 8'd0 : rd_entry.key;
		fire_res.button = mouse ? rd_entry.button : 3'd0;
		fire_res.mods   = rd_entry.mods;
		fire_res.running = 1'b1;
		fire_res.last   = 1'b1;
		rel_res.res     = mouse ? EV_MOUSE_UP : EV_KEY_UP;
		rel_res.key     = mouse ? 8'd0 : rd_entry.key;
		rel_res.button  = mouse ? rd_entry.button : 3'd0;
		rel_res.mods    = rd_entry.mods;
		rel_res.running = (cnt != '0);
		rel_res.last    = 1'b0;
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		advance   = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		fire_go   = 1'b0;
		pend_load = 1'b0;
		stop_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					case (kind)
						KIND_WRITE: state_d = ST_WRITE;
						KIND_TICK:  state_d = ST_CHECK;
						KIND_STOP:  state_d = ST_STOP;
						default:    state_d = ST_STATUS;
					endcase
				end
			end
			ST_WRITE: begin
				if (idx_ok) begin
					ctrl.ent_we     = 1'b1;
					ctrl.nz_clr_one = 1'b1;
				end
				state_d = ST_STATUS;
			end
			ST_STATUS: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_d.running = status_run;
					out_d.last    = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (ures.borrow) begin
					if (out_free) begin
						out_load      = 1'b1;
						out_d.running = 1'b1;
						out_d.last    = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (run_once_q && all_fired) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_d.last = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_STOP: begin
				ctrl.nz_clr_used = 1'b1;
				stop_go          = 1'b1;
				state_d          = ST_RELEASE;
			end
			ST_SCAN: begin
				if (ev_vld_s1 && !(run_once_q && nz_sel) && !ures.below) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_d      = fire_res;
						fire_go    = 1'b1;
						ctrl.lf_we = 1'b1;
						state_d    = ST_IDLE;
					end
				end else if (ev_vld_s1 || issue_ok) begin
					advance = 1'b1;
				end else if (out_free) begin
					out_load      = 1'b1;
					out_d.running = 1'b1;
					out_d.last    = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RELEASE: begin
				// one release word is held back so the final one can carry last
				if (ev_vld_s1 && is_rel) begin
					if (!pend_vld_q) begin
						pend_load = 1'b1;
						advance   = 1'b1;
					end else if (out_free) begin
						out_load  = 1'b1;
						out_d     = pend_q;
						pend_load = 1'b1;
						advance   = 1'b1;
					end
				end else if (ev_vld_s1 || issue_ok) begin
					advance = 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					if (pend_vld_q) begin
						out_d = pend_q;
					end else begin
						out_d.running = (cnt != '0);
					end
					out_d.last = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		ctrl.rd_en = advance && issue_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			run_once_q     <= 1'b0;
			action_count_q <= '0;
			block_until_q  <= '0;
			rd_ptr_q       <= '0;
			ev_vld_s1      <= 1'b0;
			pend_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_RUN_ONCE:     run_once_q     <= cfg_data[0];
					CFG_ACTION_COUNT: action_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (stop_go) begin
				block_until_q <= '0;
			end else if (fire_go && (rd_entry.post_delay != 24'd0)) begin
				block_until_q <= ures.sum;
			end
			if (in_accept) begin
				rd_ptr_q   <= '0;
				ev_vld_s1  <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (advance) begin
					if (issue_ok) begin
						rd_ptr_q  <= rd_ptr_q + CW'(1);
						ev_vld_s1 <= 1'b1;
					end else begin
						ev_vld_s1 <= 1'b0;
					end
				end
				if (pend_load) begin
					pend_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_kind_q             <= kind;
			item_idx_q              <= entry_index;
			item_entry_q.act        <= action_type;
			item_entry_q.key        <= key_code;
			item_entry_q.button     <= mouse_button;
			item_entry_q.mods       <= modifiers;
			item_entry_q.interval   <= interval_ms;
			item_entry_q.post_delay <= post_delay_ms;
			item_now_q              <= now_ms;
		end
		if (advance && issue_ok) begin
			ev_ptr_s1 <= rd_ptr_q[IW-1:0];
		end
		if (pend_load) begin
			pend_q <= rel_res;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_q.res;
	assign event_key    = out_q.key;
	assign event_button = out_q.button;
	assign event_mods   = out_q.mods;
	assign running      = out_q.running;
	assign last         = out_q.last;

	// item kind is kept for debug visibility of the word in flight
	`IAS_ASSERT_IMPL(a_kind_matches_state, (state_q == ST_SCAN) || (state_q == ST_CHECK), item_kind_q == KIND_TICK)
	`IAS_ASSERT_IMPL(a_ptr_in_range, ev_vld_s1 && ((state_q == ST_SCAN) || (state_q == ST_RELEASE)), 32'(ev_ptr_s1) < 32'(cnt))
	`IAS_ASSERT_IMPL(a_rd_ptr_bound, (state_q == ST_SCAN) || (state_q == ST_RELEASE), rd_ptr_q <= cnt)
	`IAS_ASSERT_NEXT(a_last_ends_item, out_load && out_d.last, state_q == ST_IDLE)

endmodule

`default_nettype wire

FILE: sv/ias_table.sv
// Action table: entry memory, last-fired memory and per-entry nonzero-stamp flags.
// Depends on ias_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ias_table import ias_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tbl_ctrl_t     ctrl,
	input  wire logic [IW-1:0] wr_addr,
	input  wire entry_t        wr_entry,
	input  wire logic [IW-1:0] rd_addr,
	input  wire logic [IW-1:0] sel_addr,
	input  wire logic [31:0]   lf_data,
	input  wire logic [CW-1:0] cnt,
	output entry_t             rd_entry,
	output logic [31:0]        rd_lf,
	output logic               nz_sel,
	output logic               all_fired
);

	entry_t             ent_mem [MAX_ENTRIES];
	logic [31:0]        lf_mem [MAX_ENTRIES];
	entry_t             rd_ent_q;
	logic [31:0]        rd_lf_q;
	logic [MAX_ENTRIES-1:0] nz_q;

	always_ff @(posedge clk) begin
		if (ctrl.ent_we) begin
			ent_mem[wr_addr] <= wr_entry;
		end
		if (ctrl.lf_we) begin
			lf_mem[sel_addr] <= lf_data;
		end
		if (ctrl.rd_en) begin
			rd_ent_q <= ent_mem[rd_addr];
			rd_lf_q  <= lf_mem[rd_addr];
		end
	end

	// a stamp of zero reads as never fired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q <= '0;
		end else begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (ctrl.nz_clr_used && (CW'(i) < cnt)) begin
					nz_q[i] <= 1'b0;
				end
				if (ctrl.nz_clr_one && (wr_addr == IW'(i))) begin
					nz_q[i] <= 1'b0;
				end
				if (ctrl.lf_we && (sel_addr == IW'(i))) begin
					nz_q[i] <= (lf_data != 32'd0);
				end
			end
		end
	end

	always_comb begin
		all_fired = 1'b1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if ((CW'(i) < cnt) && !nz_q[i]) begin
				all_fired = 1'b0;
			end
		end
	end

	assign nz_sel   = nz_q[sel_addr];
	assign rd_lf    = nz_sel ? rd_lf_q : 32'd0;
	assign rd_entry = rd_ent_q;

endmodule

`default_nettype wire

FILE: sv/ias_unit.sv
// Shared time unit: wrapped subtract with borrow, compare against a limit, add.
// Depends on ias_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ias_unit import ias_pkg::*; (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [23:0] lim,
	input  wire logic [23:0] add,
	output unit_res_t        res
);

	logic [32:0] diff;

	assign diff       = {1'b0, a} - {1'b0, b};
	assign res.borrow = diff[32];
	assign res.below  = diff[31:0] < {8'd0, lim};
	assign res.sum    = a + {8'd0, add};

endmodule

`default_nettype wire

FILE: sim/interval_action_scheduler_checker.sv
// Scoreboard for the interval action scheduler: tracks the config port and both
// channels, predicts the result words of each input word and compares them.
// Depends on ias_pkg for field types and code names.
`timescale 1ns / 1ps

module interval_action_scheduler_checker import ias_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [3:0]        entry_index,
	input  logic [1:0]        action_type,
	input  logic [7:0]        key_code,
	input  logic [2:0]        mouse_button,
	input  logic [15:0]       modifiers,
	input  logic [23:0]       interval_ms,
	input  logic [23:0]       post_delay_ms,
	input  logic [31:0]       now_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [2:0]        event_res,
	input  logic [7:0]        event_key,
	input  logic [2:0]        event_button,
	input  logic [15:0]       event_mods,
	input  logic              running,
	input  logic              last,
	output int                fail_count,
	output int                pending,
	output int                checked
);

	entry_t      slots [MAX_ENTRIES];
	logic [31:0] stamps [MAX_ENTRIES];
	logic [31:0] hold_until;
	logic        once_mode;
	logic [4:0]  slot_count;
	result_t     expected_events [$];
	int          fails;
	int          compared;

	// counts above the table size saturate
	function automatic int slots_in_use();
		return (slot_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(slot_count);
	endfunction

	// low only in run-once mode once every slot in use carries a stamp
	function automatic logic scheme_running();
		for (int i = 0; i < slots_in_use(); i++)
			if (stamps[i] == 32'd0)
				return 1'b1;
		return !once_mode;
	endfunction

	function automatic result_t event_word(input logic [2:0] res, input logic [7:0] key,
			input logic [2:0] button, input logic [15:0] mods, input logic run);
		result_t w;
		w.res = res;
		w.key = key;
		w.button = button;
		w.mods = mods;
		w.running = run;
		w.last = 1'b0;
		return w;
	endfunction

	function automatic result_t firing_word(input entry_t s);
		result_t w;
		case (s.act)
			ACT_STROKE:   w = event_word(EV_STROKE, s.key, 3'd0, s.mods, 1'b1);
			ACT_KEY_DOWN: w = event_word(EV_KEY_DOWN, s.key, 3'd0, s.mods, 1'b1);
			ACT_CLICK:    w = event_word(EV_CLICK, 8'd0, s.button, s.mods, 1'b1);
			default:      w = event_word(EV_MOUSE_DOWN, 8'd0, s.button, s.mods, 1'b1);
		endcase
		return w;
	endfunction

	task automatic schedule_word();
		result_t     batch [$];
		result_t     tail;
		int          n;
		logic        fired;
		logic        run;
		logic [31:0] since;
		n = slots_in_use();
		fired = 1'b0;
		case (kind)
			KIND_WRITE: begin
				if (entry_index < MAX_ENTRIES) begin
					slots[entry_index] = '{act: action_type, key: key_code,
						button: mouse_button, mods: modifiers, interval: interval_ms,
						post_delay: post_delay_ms};
					stamps[entry_index] = 32'd0;
				end
				batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, scheme_running()));
			end
			KIND_TICK: begin
				if (now_ms < hold_until)
					batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, 1'b1));
				else if (!scheme_running())
					batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, 1'b0));
				else begin
					// first slot in index order whose wrapped elapsed time is due
					for (int i = 0; i < n && !fired; i++) begin
						since = now_ms - stamps[i];
						if (!(once_mode && stamps[i] != 32'd0) &&
								since >= {8'd0, slots[i].interval}) begin
							batch.push_back(firing_word(slots[i]));
							if (slots[i].post_delay != 24'd0)
								hold_until = now_ms + {8'd0, slots[i].post_delay};
							stamps[i] = now_ms;
							fired = 1'b1;
						end
					end
					if (!fired)
						batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, 1'b1));
				end
			end
			KIND_STOP: begin
				run = (n != 0);
				hold_until = 32'd0;
				for (int i = 0; i < n; i++) begin
					if (slots[i].act == ACT_MOUSE_DOWN)
						batch.push_back(event_word(EV_MOUSE_UP, 8'd0, slots[i].button,
							slots[i].mods, run));
					else if (slots[i].act == ACT_KEY_DOWN)
						batch.push_back(event_word(EV_KEY_UP, slots[i].key, 3'd0,
							slots[i].mods, run));
					stamps[i] = 32'd0;
				end
				if (batch.size() == 0)
					batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, run));
			end
			default: begin
				batch.push_back(event_word(EV_NONE, 8'd0, 3'd0, 16'd0, scheme_running()));
			end
		endcase
		tail = batch.pop_back();
		tail.last = 1'b1;
		batch.push_back(tail);
		foreach (batch[j])
			expected_events.push_back(batch[j]);
	endtask

	task automatic compare_field(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			once_mode = 1'b0;
			slot_count = 5'd0;
			hold_until = 32'd0;
			foreach (stamps[i])
				stamps[i] = 32'd0;
			expected_events.delete();
			fails = 0;
			compared = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_RUN_ONCE)
					once_mode = cfg_data[0];
				else
					slot_count = cfg_data;
			end
			// outputs first: a word leaving now belongs to an earlier input
			if (out_valid && !out_stall) begin
				got = '{res: event_res, key: event_key, button: event_button,
					mods: event_mods, running: running, last: last};
				if (expected_events.size() == 0) begin
					fails++;
					$display("%0t: result word with nothing expected, expected none actual %0h",
						$time, got);
				end else begin
					want = expected_events.pop_front();
					compare_field("event_res", 16'(want.res), 16'(got.res));
					compare_field("event_key", 16'(want.key), 16'(got.key));
					compare_field("event_button", 16'(want.button), 16'(got.button));
					compare_field("event_mods", want.mods, got.mods);
					compare_field("running", 16'(want.running), 16'(got.running));
					compare_field("last", 16'(want.last), 16'(got.last));
					compared++;
				end
			end
			if (in_valid && !in_stall)
				schedule_word();
		end
		fail_count <= fails;
		pending <= expected_events.size();
		checked <= compared;
	end

endmodule

FILE: sim/interval_action_scheduler_tb.sv
// Testbench top for the interval action scheduler: clock, reset, word stimulus,
// config writes and the verdict. Needs ias_pkg, the block and the checker.
`timescale 1ns / 1ps

module interval_action_scheduler_tb import ias_pkg::*;;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int SLOT_TOTAL    = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 54;
	// per phase: run-once flag and slot count, phase 0 rightmost
	localparam logic [PHASES-1:0] ONCE_PLAN = 8'b1010_1010;
	localparam logic [PHASES-1:0][4:0] COUNT_PLAN =
		{5'd17, 5'd9, 5'd0, 5'd31, 5'd16, 5'd1, 5'd4, 5'd16};

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  idx;
		logic [1:0]  act;
		logic [7:0]  key;
		logic [2:0]  btn;
		logic [15:0] mods;
		logic [23:0] ivl;
		logic [23:0] pdl;
		logic [31:0] now;
	} word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        kind;
	logic [3:0]        entry_index;
	logic [1:0]        action_type;
	logic [7:0]        key_code;
	logic [2:0]        mouse_button;
	logic [15:0]       modifiers;
	logic [23:0]       interval_ms;
	logic [23:0]       post_delay_ms;
	logic [31:0]       now_ms;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        event_res;
	logic [7:0]        event_key;
	logic [2:0]        event_button;
	logic [15:0]       event_mods;
	logic              running;
	logic              last;

	logic        calm = 1'b0;
	logic [31:0] clock_ms;
	int          fail_count;
	int          pending;
	int          checked;
	int          words_sent;
	int          settings;
	int          quiet;

	interval_action_scheduler u_dut (.*);

	interval_action_scheduler_checker u_check (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk)
		out_stall = !calm && ($urandom_range(0, 99) < 8);

	// cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("interval_action_scheduler verification failed");
			$finish;
		end
	end

	function automatic word_t noise_word();
		word_t w;
		w.kind = 2'($urandom);
		w.idx = 4'($urandom);
		w.act = 2'($urandom);
		w.key = 8'($urandom);
		w.btn = 3'($urandom);
		w.mods = 16'($urandom);
		w.ivl = 24'($urandom);
		w.pdl = 24'($urandom);
		w.now = $urandom;
		return w;
	endfunction

	task automatic send(input word_t w);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 8) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		kind = w.kind;
		entry_index = w.idx;
		action_type = w.act;
		key_code = w.key;
		mouse_button = w.btn;
		modifiers = w.mods;
		interval_ms = w.ivl;
		post_delay_ms = w.pdl;
		now_ms = w.now;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// hold off the sender until every expected word is back and the block is idle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		settings++;
	endtask

	task automatic write_slot(input logic [3:0] idx, input logic [1:0] act,
			input logic [7:0] key, input logic [2:0] btn, input logic [15:0] mods,
			input logic [23:0] ivl, input logic [23:0] pdl);
		word_t w;
		w = noise_word();
		w.kind = KIND_WRITE;
		w.idx = idx;
		w.act = act;
		w.key = key;
		w.btn = btn;
		w.mods = mods;
		w.ivl = ivl;
		w.pdl = pdl;
		send(w);
	endtask

	task automatic tick_at(input logic [31:0] t);
		word_t w;
		w = noise_word();
		w.kind = KIND_TICK;
		w.now = t;
		send(w);
	endtask

	task automatic plain_word(input logic [1:0] k);
		word_t w;
		w = noise_word();
		w.kind = k;
		send(w);
	endtask

	// mostly short intervals so slots keep firing; now and then a huge one
	task automatic random_slot(input logic [3:0] idx);
		logic [23:0] ivl;
		logic [23:0] pdl;
		ivl = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 150));
		case ($urandom_range(0, 9))
			0:          pdl = 24'($urandom);
			1, 2, 3, 4: pdl = 24'($urandom_range(1, 80));
			default:    pdl = 24'd0;
		endcase
		write_slot(idx, 2'($urandom), 8'($urandom), 3'($urandom), 16'($urandom), ivl, pdl);
	endtask

	initial begin
		int roll;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RUN_ONCE;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		entry_index = '0;
		action_type = ACT_STROKE;
		key_code = '0;
		mouse_button = '0;
		modifiers = '0;
		interval_ms = '0;
		post_delay_ms = '0;
		now_ms = '0;
		clock_ms = '0;
		words_sent = 0;
		settings = 0;
		quiet = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no slots in use: bare answers, stop reports not running
		tick_at(32'd0);
		plain_word(KIND_STOP);
		plain_word(KIND_SPARE);
		write_slot(4'd0, ACT_STROKE, 8'hFF, 3'd7, 16'hFFFF, 24'd100, 24'd0);
		write_slot(4'd1, ACT_KEY_DOWN, 8'h00, 3'd0, 16'h0000, 24'd0, 24'd50);
		write_slot(4'd2, ACT_CLICK, 8'hA5, 3'd7, 16'h8001, 24'hFFFFFF, 24'hFFFFFF);
		write_slot(4'd3, ACT_MOUSE_DOWN, 8'h5A, 3'd0, 16'h7FFE, 24'd1, 24'd1);
		drain();
		set_reg(CFG_ACTION_COUNT, 5'd4);
		// fire at time zero, blocked tick, wrapped elapsed time
		tick_at(32'd0);
		tick_at(32'd10);
		tick_at(32'd50);
		tick_at(32'hFFFF_FFF0);
		tick_at(32'd100);
		plain_word(KIND_STOP);
		drain();
		set_reg(CFG_RUN_ONCE, 5'd1);
		tick_at(32'd200);
		tick_at(32'd200);
		tick_at(32'd210);
		tick_at(32'h0100_0000);
		tick_at(32'hFFFF_FFFF);
		tick_at(32'd5);
		write_slot(4'd1, ACT_KEY_DOWN, 8'h81, 3'd5, 16'h0F0F, 24'd3, 24'd0);
		drain();
		set_reg(CFG_ACTION_COUNT, 5'd0);
		tick_at(32'd7);

		// load every slot so any count reads only written entries
		for (int i = 0; i < SLOT_TOTAL; i++)
			random_slot(4'(i));
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm = (ph == 3);
			set_reg(CFG_RUN_ONCE, 5'($urandom_range(0, 15) << 1) | 5'(ONCE_PLAN[ph]));
			set_reg(CFG_ACTION_COUNT, COUNT_PLAN[ph]);
			clock_ms = (ph == 4) ? 32'hFFFF_FF00 : $urandom;
			repeat (PHASE_WORDS) begin
				roll = $urandom_range(0, 99);
				if (roll < 68) begin
					clock_ms += $urandom_range(0, 60);
					tick_at(clock_ms);
				end else if (roll < 82)
					random_slot(4'($urandom_range(0, 15)));
				else if (roll < 88)
					plain_word(KIND_STOP);
				else if (roll < 91)
					plain_word(KIND_SPARE);
				else if (roll < 96) begin
					clock_ms = $urandom;
					tick_at(clock_ms);
				end else begin
					drain();
					tick_at(clock_ms);
				end
			end
		end
		calm = 1'b0;
		drain();

		$display("Drove %0d input words (writes, ticks, stops, spare kind) over %0d register writes",
			words_sent, settings);
		$display("Compared %0d result words, run-once and free-running, wrap and block-until",
			checked);
		if (fail_count == 0)
			$display("interval_action_scheduler verification clean");
		else
			$display("interval_action_scheduler verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/ias_pkg.sv
sv/ias_table.sv
sv/ias_unit.sv
sv/interval_action_scheduler.sv
sim/interval_action_scheduler_checker.sv
sim/interval_action_scheduler_tb.sv
